[rtl/core/ootc_pkg.sv]
// ----------------------------------------------------------------------------
// ootc_pkg
// Shared types and constants for the op-amp offset trim calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package ootc_pkg;

   localparam int unsigned TRIM_W   = 8;
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned STEP_W   = 5;
   localparam int unsigned CSR_W    = 8;

   typedef enum logic [2:0] {
      ST_RUNNING     = 3'd0,
      ST_DONE        = 3'd1,
      ST_POS_RANGE   = 3'd2,
      ST_NEG_RANGE   = 3'd3,
      ST_ITER_LIMIT  = 3'd4,
      ST_OSCILLATING = 3'd5,
      ST_IDLE        = 3'd6
   } status_type;

   typedef enum logic {
      CSR_TOLERANCE = 1'b0,
      CSR_ITER_LIMIT = 1'b1
   } csr_index_type;

   localparam logic [TRIM_W-1:0] TRIM_MAX    = 8'hFF;
   localparam logic [TRIM_W-1:0] TRIM_MIN    = 8'h00;
   localparam logic [7:0]        OSC_PATTERN = 8'b1010_1010;

   // error magnitude thresholds for the coarse / medium step
   localparam logic [SAMPLE_W-1:0] MAG_COARSE = 12'd10;
   localparam logic [SAMPLE_W-1:0] MAG_MEDIUM = 12'd5;

   localparam logic signed [STEP_W-1:0] STEP_COARSE = 5'sd10;
   localparam logic signed [STEP_W-1:0] STEP_MEDIUM = 5'sd2;
   localparam logic signed [STEP_W-1:0] STEP_FINE   = 5'sd1;
   localparam logic signed [STEP_W-1:0] STEP_NONE   = 5'sd0;

   localparam logic [CSR_W-1:0] TOLERANCE_RESET  = 8'd1;
   localparam logic [CSR_W-1:0] ITER_LIMIT_RESET = 8'd255;

   typedef struct packed {
      logic [TRIM_W-1:0] trim;
      logic [7:0]        history;
      logic [7:0]        count;
      status_type        status;
   } cal_state_type;

   typedef struct packed {
      logic                  start_run;
      logic [TRIM_W-1:0]     initial_trim;
      logic [SAMPLE_W-1:0]   output_sample;
      logic [SAMPLE_W-1:0]   input_sample;
   } cal_item_type;

endpackage

`default_nettype wire

[rtl/core/ootc_step.sv]
// ----------------------------------------------------------------------------
// ootc_step
// One calibration step: error, step choice, trim clamp and status checks.
// ----------------------------------------------------------------------------
`default_nettype none

module ootc_step (
   input  wire ootc_pkg::cal_item_type           item,
   input  wire ootc_pkg::cal_state_type          cur,
   input  wire logic [ootc_pkg::CSR_W-1:0]       tolerance,
   input  wire logic [ootc_pkg::CSR_W-1:0]       iteration_limit,
   output ootc_pkg::cal_state_type               nxt,
   output logic signed [ootc_pkg::STEP_W-1:0]    step
);

   logic signed [ootc_pkg::SAMPLE_W:0]   err;
   logic                                 neg;
   logic [ootc_pkg::SAMPLE_W-1:0]        mag;
   logic signed [ootc_pkg::STEP_W-1:0]   step_mag;
   logic signed [ootc_pkg::STEP_W-1:0]   step_sel;
   logic [7:0]                           hist_next;
   logic [7:0]                           count_next;
   logic signed [ootc_pkg::TRIM_W+1:0]   sum;
   logic [ootc_pkg::TRIM_W-1:0]          trim_clamped;
   logic                                 within_tol;

   always_comb begin
      err = $signed({1'b0, item.output_sample}) - $signed({1'b0, item.input_sample});
      neg = err[ootc_pkg::SAMPLE_W];
      // |err| fits in 12 bits since both samples are 12-bit unsigned
      mag = neg ? ootc_pkg::SAMPLE_W'(-err) : err[ootc_pkg::SAMPLE_W-1:0];

      if (mag > ootc_pkg::MAG_COARSE) begin
         step_mag = ootc_pkg::STEP_COARSE;
      end else if (mag > ootc_pkg::MAG_MEDIUM) begin
         step_mag = ootc_pkg::STEP_MEDIUM;
      end else begin
         step_mag = ootc_pkg::STEP_FINE;
      end
      step_sel = neg ? -step_mag : step_mag;

      hist_next  = {cur.history[6:0], ~neg};
      count_next = cur.count + 8'd1;
      within_tol = (mag <= {4'b0, tolerance});

      sum = $signed({2'b00, cur.trim})
          + $signed({{(ootc_pkg::TRIM_W+2-ootc_pkg::STEP_W){step_sel[ootc_pkg::STEP_W-1]}},
                     step_sel});
      if (sum[ootc_pkg::TRIM_W+1]) begin
         trim_clamped = ootc_pkg::TRIM_MIN;
      end else if (sum[ootc_pkg::TRIM_W]) begin
         trim_clamped = ootc_pkg::TRIM_MAX;
      end else begin
         trim_clamped = sum[ootc_pkg::TRIM_W-1:0];
      end

      nxt  = cur;
      step = ootc_pkg::STEP_NONE;

      if (item.start_run) begin
         nxt.trim    = item.initial_trim;
         nxt.history = 8'd0;
         nxt.count   = 8'd0;
         nxt.status  = ootc_pkg::ST_RUNNING;
      end else if (cur.status == ootc_pkg::ST_RUNNING) begin
         nxt.history = hist_next;
         if (within_tol) begin
            nxt.status = ootc_pkg::ST_DONE;
         end else begin
            step = step_sel;
            if (cur.trim == ootc_pkg::TRIM_MAX && !neg) begin
               nxt.status = ootc_pkg::ST_POS_RANGE;
            end else if (cur.trim == ootc_pkg::TRIM_MIN && neg) begin
               nxt.status = ootc_pkg::ST_NEG_RANGE;
            end else begin
               nxt.trim = trim_clamped;
            end
            nxt.count = count_next;
            // later checks win
            if (count_next == iteration_limit) begin
               nxt.status = ootc_pkg::ST_ITER_LIMIT;
            end
            if (hist_next == ootc_pkg::OSC_PATTERN) begin
               nxt.status = ootc_pkg::ST_OSCILLATING;
            end
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/opamp_offset_trim_calibrator_unit.sv]
// ----------------------------------------------------------------------------
// opamp_offset_trim_calibrator_unit
// Steps an 8-bit offset trim toward zero amplifier offset, one word per sample.
// ----------------------------------------------------------------------------
// Each request word is captured in an input register; one calibration step is
// evaluated on it against the held trim/history/count state and the result
// lands in the response register while the state is updated. The block takes
// one word per cycle unless the response stalls; throughput is set by the
// state update loop (trim, sign history, adjustment count). A stalled response
// backs up into the input register and then deasserts req_tready. tolerance
// and iteration_limit are written through the csr port while no word is in
// flight; the user is bound to this, the block does not enforce it. Status
// codes: 0 running, 1 done, 2 positive range, 3 negative range, 4 iteration
// limit, 5 oscillating, 6 idle.
`default_nettype none

module opamp_offset_trim_calibrator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // initial_trim[7:0], output_sample[19:8],
                                         // input_sample[31:20]
   input  wire logic [0:0]  req_tuser,   // start_run[0]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // trim_value[7:0], step_applied[12:8],
                                         // status[15:13]
   // configuration
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);

   logic [ootc_pkg::CSR_W-1:0]          tol_ff;
   logic [ootc_pkg::CSR_W-1:0]          limit_ff;

   logic                                in_valid_ff;
   ootc_pkg::cal_item_type              in_item_ff;
   ootc_pkg::cal_state_type             state_ff;
   ootc_pkg::cal_state_type             state_in;
   logic signed [ootc_pkg::STEP_W-1:0]  step;

   logic                                out_valid_ff;
   logic [15:0]                         out_data_ff;
   logic                                advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= ootc_pkg::TOLERANCE_RESET;
         limit_ff <= ootc_pkg::ITER_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (ootc_pkg::csr_index_type'(csr_addr))
            ootc_pkg::CSR_TOLERANCE:  tol_ff   <= csr_wdata;
            ootc_pkg::CSR_ITER_LIMIT: limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.start_run     <= req_tuser[0];
         in_item_ff.initial_trim  <= req_tdata[7:0];
         in_item_ff.output_sample <= req_tdata[19:8];
         in_item_ff.input_sample  <= req_tdata[31:20];
      end
   end

   ootc_step u_step (
      .item            (in_item_ff),
      .cur             (state_ff),
      .tolerance       (tol_ff),
      .iteration_limit (limit_ff),
      .nxt             (state_in),
      .step            (step)
   );

   // calibration state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.trim    <= '0;
         state_ff.history <= '0;
         state_ff.count   <= '0;
         state_ff.status  <= ootc_pkg::ST_IDLE;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {state_in.status, step, state_in.trim};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // ------------------------------------------------------------------------
   // assertions

   a_step_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[12:8] != 5'd0) |->
         (rsp_tdata[15:13] != ootc_pkg::ST_DONE && rsp_tdata[15:13] != ootc_pkg::ST_IDLE))
      else $error("nonzero step reported with done or idle status");

   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("calibration state changed without an evaluated word");

   a_advance_out : assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_tvalid && rsp_tdata == $past({state_in.status, step, state_in.trim})))
      else $error("evaluated word did not reach the response register");

   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while pipeline is full");

endmodule

`default_nettype wire
